// ===== src/i2c_eeprom_byte_master_defines.svh =====
// ----------------------------------------------------------------------------
// i2c eeprom byte master assertion macros
// shared property shells for the bus master checks
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define I2CBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define I2CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// types, constants and reset values shared by the i2c eeprom byte master
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	localparam int unsigned DIVIDER_WIDTH = 16;
	localparam int unsigned QP_W          = 16;
	localparam int unsigned DEV_W         = 7;
	localparam int unsigned ACKW_W        = 8;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 16;
	// compare width for count+1 against the quarter period
	localparam int unsigned CMP_W = (DIVIDER_WIDTH + 1 > QP_W + 1) ? DIVIDER_WIDTH + 1 : QP_W + 1;

	localparam logic [1:0] QTR_0 = 2'd0;
	localparam logic [1:0] QTR_1 = 2'd1;
	localparam logic [1:0] QTR_2 = 2'd2;
	localparam logic [1:0] QTR_3 = 2'd3;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic       RW_WRITE      = 1'b0;
	localparam logic       RW_READ       = 1'b1;
	localparam logic       CMD_WRITE     = 1'b1;

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_START    = 14'b00000000000010,
		ST_TX_DEV   = 14'b00000000000100,
		ST_ACK_DEV  = 14'b00000000001000,
		ST_TX_ADDR  = 14'b00000000010000,
		ST_ACK_ADDR = 14'b00000000100000,
		ST_TX_DATA  = 14'b00000001000000,
		ST_ACK_DATA = 14'b00000010000000,
		ST_RESTART  = 14'b00000100000000,
		ST_TX_DEVR  = 14'b00001000000000,
		ST_ACK_DEVR = 14'b00010000000000,
		ST_RX       = 14'b00100000000000,
		ST_STOP     = 14'b01000000000000,
		ST_DONE     = 14'b10000000000000
	} stage_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEVICE_ADDRESS = 2'd0,
		CFG_QUARTER_PERIOD = 2'd1,
		CFG_ACK_WAIT_LIMIT = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [DEV_W-1:0]  device_address;
		logic [QP_W-1:0]   quarter_period;
		logic [ACKW_W-1:0] ack_wait_limit;
	} cfg_t;

	typedef struct packed {
		stage_t                   stage;
		logic [1:0]               quarter;
		logic [DIVIDER_WIDTH-1:0] div_count;
		logic [3:0]               bit_count;
		logic [7:0]               shift_byte;
		logic [ACKW_W-1:0]        ack_timer;
		logic                     held_command;
		logic [7:0]               held_address;
		logic [7:0]               held_data;
		logic [7:0]               received_byte;
		logic                     ack_fault;
	} seq_state_t;

	typedef struct packed {
		logic                     tick;
		logic [DIVIDER_WIDTH-1:0] count_inc;
	} div_status_t;

	typedef struct packed {
		logic       scl;
		logic       sda_low;
		logic       write_protect;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_missing;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		device_address: 7'd80,
		quarter_period: 16'd100,
		ack_wait_limit: 8'd255
	};

	localparam seq_state_t SEQ_RESET = '{
		stage:         ST_IDLE,
		quarter:       QTR_0,
		div_count:     '0,
		bit_count:     '0,
		shift_byte:    '0,
		ack_timer:     '0,
		held_command:  1'b0,
		held_address:  '0,
		held_data:     '0,
		received_byte: '0,
		ack_fault:     1'b0
	};

endpackage

// ===== src/i2cbm_divider.sv =====
// ----------------------------------------------------------------------------
// i2cbm_divider
// quarter-bit divider compare: flags the tick that ends a line-change step
// ----------------------------------------------------------------------------
module i2cbm_divider (
	input  logic [i2cbm_pkg::DIVIDER_WIDTH-1:0] count,
	input  logic [i2cbm_pkg::QP_W-1:0]          quarter_period,
	output i2cbm_pkg::div_status_t              status
);
	import i2cbm_pkg::*;

	logic [CMP_W-1:0] count_plus;
	logic [CMP_W-1:0] qp_eff;
	logic             full;

	always_comb begin
		count_plus = CMP_W'(count) + CMP_W'(1);
		// zero period behaves as one
		qp_eff     = (quarter_period == '0) ? CMP_W'(1) : CMP_W'(quarter_period);
		full       = (count == '1);
		status.tick      = (count_plus >= qp_eff) || full;
		status.count_inc = count_plus[DIVIDER_WIDTH-1:0];
	end

endmodule

// ===== src/i2cbm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cbm_seq
// bus sequencer next state and line levels for one tick
// ----------------------------------------------------------------------------
module i2cbm_seq (
	input  i2cbm_pkg::seq_state_t  cur,
	input  i2cbm_pkg::cfg_t        cfg,
	input  i2cbm_pkg::div_status_t div,
	input  logic                   go,
	input  logic                   command,
	input  logic [7:0]             mem_address,
	input  logic [7:0]             write_data,
	input  logic                   sda_in,
	output i2cbm_pkg::seq_state_t  nxt,
	output i2cbm_pkg::result_t     res
);
	import i2cbm_pkg::*;

	logic       is_ack;
	logic [3:0] bc_inc;

	always_comb begin
		nxt    = cur;
		bc_inc = cur.bit_count + 4'd1;
		is_ack = (cur.stage == ST_ACK_DEV) || (cur.stage == ST_ACK_ADDR) ||
			(cur.stage == ST_ACK_DATA) || (cur.stage == ST_ACK_DEVR);

		if (cur.stage == ST_IDLE || cur.stage == ST_DONE) begin
			nxt.stage   = ST_IDLE;
			nxt.quarter = QTR_0;
			if (go) begin
				nxt.held_command = command;
				nxt.held_address = mem_address;
				nxt.held_data    = write_data;
				nxt.ack_fault    = 1'b0;
				nxt.ack_timer    = '0;
				nxt.bit_count    = '0;
				nxt.div_count    = '0;
				nxt.stage        = ST_START;
			end
		end else if (!div.tick) begin
			nxt.div_count = div.count_inc;
		end else begin
			nxt.div_count = '0;
			if (is_ack && cur.quarter == QTR_1) begin
				// ack wait: scl high, hold the quarter until sda low or timeout
				if (!sda_in) begin
					nxt.quarter = QTR_2;
				end else if (cur.ack_timer >= cfg.ack_wait_limit) begin
					nxt.ack_fault = 1'b1;
					nxt.quarter   = QTR_2;
				end else begin
					nxt.ack_timer = cur.ack_timer + ACKW_W'(1);
				end
			end else if (cur.quarter != QTR_3) begin
				if (cur.stage == ST_RX && cur.quarter == QTR_2)
					nxt.shift_byte = {cur.shift_byte[6:0], sda_in};
				nxt.quarter = cur.quarter + 2'd1;
			end else begin
				nxt.quarter = QTR_0;
				unique case (cur.stage)
					ST_START: begin
						nxt.shift_byte = {cfg.device_address, RW_WRITE};
						nxt.bit_count  = '0;
						nxt.stage      = ST_TX_DEV;
					end
					ST_RESTART: begin
						nxt.shift_byte = {cfg.device_address, RW_READ};
						nxt.bit_count  = '0;
						nxt.stage      = ST_TX_DEVR;
					end
					ST_TX_DEV, ST_TX_ADDR, ST_TX_DATA, ST_TX_DEVR: begin
						nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
						nxt.bit_count  = bc_inc;
						if (bc_inc >= BITS_PER_BYTE) begin
							nxt.bit_count = '0;
							nxt.ack_timer = '0;
							unique case (cur.stage)
								ST_TX_DEV:  nxt.stage = ST_ACK_DEV;
								ST_TX_ADDR: nxt.stage = ST_ACK_ADDR;
								ST_TX_DATA: nxt.stage = ST_ACK_DATA;
								default:    nxt.stage = ST_ACK_DEVR;
							endcase
						end
					end
					ST_ACK_DEV: begin
						nxt.shift_byte = cur.held_address;
						nxt.bit_count  = '0;
						nxt.stage      = ST_TX_ADDR;
					end
					ST_ACK_ADDR: begin
						nxt.bit_count = '0;
						if (cur.held_command == CMD_WRITE) begin
							nxt.shift_byte = cur.held_data;
							nxt.stage      = ST_TX_DATA;
						end else begin
							nxt.stage = ST_RESTART;
						end
					end
					ST_ACK_DATA: nxt.stage = ST_STOP;
					ST_ACK_DEVR: begin
						nxt.shift_byte = '0;
						nxt.bit_count  = '0;
						nxt.stage      = ST_RX;
					end
					ST_RX: begin
						nxt.bit_count = bc_inc;
						if (bc_inc >= BITS_PER_BYTE) begin
							nxt.bit_count     = '0;
							nxt.received_byte = cur.shift_byte;
							nxt.stage         = ST_STOP;
						end
					end
					ST_STOP: nxt.stage = ST_DONE;
					default: nxt.stage = ST_IDLE;
				endcase
			end
		end
	end

	// line levels follow the state after this tick
	always_comb begin
		res.scl           = (nxt.quarter == QTR_1) || (nxt.quarter == QTR_2);
		res.sda_low       = 1'b0;
		res.write_protect = 1'b0;
		res.busy          = 1'b1;
		res.done          = 1'b0;
		res.read_data     = nxt.received_byte;
		res.ack_missing   = nxt.ack_fault;
		unique case (nxt.stage)
			ST_IDLE: begin
				res.scl  = 1'b1;
				res.busy = 1'b0;
			end
			ST_DONE: begin
				res.scl  = 1'b1;
				res.busy = 1'b0;
				res.done = 1'b1;
			end
			ST_START, ST_RESTART: res.sda_low = nxt.quarter[1];
			ST_TX_DEV, ST_TX_ADDR, ST_TX_DATA, ST_TX_DEVR: res.sda_low = !nxt.shift_byte[7];
			ST_STOP: begin
				res.scl     = (nxt.quarter != QTR_0);
				res.sda_low = !nxt.quarter[1];
			end
			default: ;
		endcase
	end

endmodule

// ===== src/i2c_eeprom_byte_master.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// i2c master for an eeprom with 8-bit word addresses: byte write, random read
// ----------------------------------------------------------------------------
// Each input item is one bus tick and produces exactly one result item that
// carries the scl and open-drain sda levels for that tick, plus busy, a
// one-tick done pulse, the last byte read and an ack-missing flag. The block
// takes one item per clock cycle while not stalled: the whole tick update
// (divider compare, sequencer step, line decode) sits between the state
// registers and the result register; that loop sets the rate, and each
// result is out in the cycle after accept. The result register lets a new
// item in while the previous result is taken; input stalls only while a
// result is held under output stall. go is honoured in idle and on the done
// tick. Configuration (device address, quarter period, ack wait limit) is
// written through the cfg port, always ready, and should change only idle.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [i2cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2cbm_pkg::CFG_DATA_W-1:0] cfg_data,
	// tick items in
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             go,
	input  logic                             command,
	input  logic [7:0]                       mem_address,
	input  logic [7:0]                       write_data,
	input  logic                             sda_in,
	// tick results out
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             scl,
	output logic                             sda_low,
	output logic                             write_protect,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [7:0]                       read_data,
	output logic                             ack_missing
);
	import i2cbm_pkg::*;

	`include "i2c_eeprom_byte_master_defines.svh"

	cfg_t        cfg_q;
	seq_state_t  state_q;
	seq_state_t  state_nxt;
	div_status_t div_stat;
	result_t     res_nxt;
	result_t     res_q;
	logic        out_valid_q;
	logic        accept;
	logic        in_done;
	logic        idle_go;
	logic        start_open;
	logic        in_ack_wait;

	// register writes never wait
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[DEV_W-1:0];
				CFG_QUARTER_PERIOD: cfg_q.quarter_period <= cfg_data[QP_W-1:0];
				CFG_ACK_WAIT_LIMIT: cfg_q.ack_wait_limit <= cfg_data[ACKW_W-1:0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// quarter-bit divider compare
	i2cbm_divider u_div (
		.count          (state_q.div_count),
		.quarter_period (cfg_q.quarter_period),
		.status         (div_stat)
	);

	// one tick of the bus sequencer
	i2cbm_seq u_seq (
		.cur         (state_q),
		.cfg         (cfg_q),
		.div         (div_stat),
		.go          (go),
		.command     (command),
		.mem_address (mem_address),
		.write_data  (write_data),
		.sda_in      (sda_in),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// a held result under stall blocks the next item
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_RESET;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with each accepted item
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign scl           = res_q.scl;
	assign sda_low       = res_q.sda_low;
	assign write_protect = res_q.write_protect;
	assign busy_res      = res_q.busy;
	assign done_res      = res_q.done;
	assign read_data     = res_q.read_data;
	assign ack_missing   = res_q.ack_missing;

	// checks on the sequencer

	assign in_done     = (state_q.stage == ST_DONE);
	assign idle_go     = accept && go && (state_q.stage == ST_IDLE);
	assign start_open  = (state_q.stage == ST_START) && (state_q.quarter == QTR_0) &&
		(state_q.div_count == '0);
	assign in_ack_wait = (state_q.quarter == QTR_1) &&
		((state_q.stage == ST_ACK_DEV) || (state_q.stage == ST_ACK_ADDR) ||
		(state_q.stage == ST_ACK_DATA) || (state_q.stage == ST_ACK_DEVR));

	// done lasts a single tick
	`I2CBM_ASSERT_NEXT(a_done_one_tick, accept && in_done, !in_done, "done held past one tick")

	// a request in idle opens a start cell with a cleared divider
	`I2CBM_ASSERT_NEXT(a_go_starts, idle_go, start_open, "go in idle gave no start cell")

	// the ack timer never runs past the wait limit while waiting
	`I2CBM_ASSERT_NOW(a_ack_timer_bound, in_ack_wait, state_q.ack_timer <= cfg_q.ack_wait_limit, "ack timer past limit")

	// input stalls only behind a held result
	`I2CBM_ASSERT_NOW(a_stall_cause, in_stall, out_valid_q, "input stalled with no result held")

endmodule
